/* sv/csbl_pkg.sv */
package csbl_pkg;

   localparam int SUM_W = 32;
   localparam int MEAN_W = 14;
   localparam int CSR_IDX_W = 3;
   localparam logic [MEAN_W-1:0] MEAN_MAX = 14'd8192;
   localparam int CORR_MAX = 100;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SAMPLES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_ONE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_TWO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_FOUR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_FIVE = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // Clamps a signed value to plus or minus a nonnegative bound.
   function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
                                                    input logic signed [15:0] b);
      logic signed [15:0] r;
      r = v;
      if (v > b) r = b;
      if (v < -b) r = -b;
      return r;
   endfunction

endpackage

/* sv/csbl_if.sv */
interface csbl_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  zone_number;
   logic [31:0] sum_first;
   logic [31:0] sum_second;
   logic [31:0] sum_third;
   logic [31:0] count_first;
   logic [31:0] count_second;
   logic [31:0] count_third;
   logic        store_request;
   modport source (output valid, zone_number, sum_first, sum_second, sum_third,
                   count_first, count_second, count_third, store_request,
                   input ready);
   modport sink (input valid, zone_number, sum_first, sum_second, sum_third,
                 count_first, count_second, count_third, store_request,
                 output ready);
endinterface

interface csbl_rsp_if;
   logic              valid;
   logic              ready;
   logic [13:0]       mean_first;
   logic [13:0]       mean_second;
   logic [13:0]       mean_third;
   logic [13:0]       mean_all;
   logic              learn_ready;
   logic signed [7:0] corr_first;
   logic signed [7:0] corr_second;
   logic signed [7:0] corr_third;
   logic signed [7:0] table_first;
   logic signed [7:0] table_second;
   logic signed [7:0] table_third;
   logic              zone_error;
   modport source (output valid, mean_first, mean_second, mean_third, mean_all,
                   learn_ready, corr_first, corr_second, corr_third, table_first,
                   table_second, table_third, zone_error, input ready);
   modport sink (input valid, mean_first, mean_second, mean_third, mean_all,
                 learn_ready, corr_first, corr_second, corr_third, table_first,
                 table_second, table_third, zone_error, output ready);
endinterface

interface csbl_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/cylinder_speed_balance_learner.sv */
// An accepted item passes through three parallel bit-serial restoring dividers, then a
// finish state and an output state that holds the result until it is taken.
// A new item is accepted only in the idle state, so the block takes no new item until
// the result of the last one has been taken.
// Reset (synchronous, active high) clears the configuration registers, the learned flags
// and the control state; learned table values are undefined until written.
module cylinder_speed_balance_learner #(
   parameter int ZONE_COUNT = 20
) (
   input logic clock,
   input logic reset,
   csbl_req_if.sink req,
   csbl_rsp_if.source rsp,
   csbl_csr_if.sink csr
);
   localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int SW = csbl_pkg::SUM_W;

   csbl_pkg::state_type state_ff, state_in;

   logic [7:0] min_ff;
   logic [7:0] lim_ff [5];
   logic [ZONE_COUNT-1:0] flags_ff;
   logic signed [7:0] mem1 [ZONE_COUNT];
   logic signed [7:0] mem2 [ZONE_COUNT];
   logic signed [7:0] mem3 [ZONE_COUNT];
   logic signed [7:0] old_ff [3];

   logic [4:0] zone_ff;
   logic store_ff;
   logic [SW-1:0] quo_ff [3];
   logic [SW-1:0] den_ff [3];
   logic [SW-1:0] rem_ff [3];
   logic [2:0] ack_ff;
   logic [5:0] cnt_ff;

   // Output register.
   logic [13:0] m_ff [3];
   logic [13:0] mall_ff;
   logic signed [7:0] c_ff [3];
   logic signed [7:0] t_ff [3];
   logic ready_out_ff, err_ff;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == csbl_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == csbl_pkg::ST_OUTPUT);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         for (int i = 0; i < 5; i++) lim_ff[i] <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            csbl_pkg::REG_MIN_SAMPLES: min_ff <= csr.data;
            csbl_pkg::REG_LIMIT_ONE: lim_ff[0] <= csr.data;
            csbl_pkg::REG_LIMIT_TWO: lim_ff[1] <= csr.data;
            csbl_pkg::REG_LIMIT_THREE: lim_ff[2] <= csr.data;
            csbl_pkg::REG_LIMIT_FOUR: lim_ff[3] <= csr.data;
            csbl_pkg::REG_LIMIT_FIVE: lim_ff[4] <= csr.data;
            default: ;
         endcase
      end
   end

   // Finish-stage arithmetic from the divider results.
   logic [13:0] mean_w [3];
   logic [15:0] msum;
   logic [31:0] mprod;
   logic [13:0] mall_w;
   logic [2:0] grp;
   logic signed [15:0] lim_w;
   logic signed [15:0] corr_w [3];
   logic valid_zone;
   logic [ZW-1:0] ix;
   logic had;
   logic signed [7:0] old_w [3];
   logic signed [7:0] new_w [3];
   logic signed [15:0] avg;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!ack_ff[k]) mean_w[k] = '0;
         else if (quo_ff[k] > SW'(csbl_pkg::MEAN_MAX)) mean_w[k] = csbl_pkg::MEAN_MAX;
         else mean_w[k] = quo_ff[k][13:0];
      end
      msum = 16'(mean_w[0]) + 16'(mean_w[1]) + 16'(mean_w[2]);
      // Division by three as a reciprocal multiply; exact for sums below 2^17.
      mprod = 32'(msum) * 32'd43691;
      mall_w = 14'(mprod >> 17);
      if (zone_ff == 5'd0) grp = 3'd0;
      else if (((zone_ff - 5'd1) >> 2) >= 5'd4) grp = 3'd5;
      else grp = 3'(((zone_ff - 5'd1) >> 2) + 5'd1);
      if (grp == 3'd0) lim_w = '0;
      else begin
         lim_w = 16'(signed'(lim_ff[grp - 3'd1]));
         if (lim_w < 0) lim_w = -lim_w;
         if (lim_w > 16'sd100) lim_w = 16'sd100;
      end
      for (int k = 0; k < 3; k++)
         corr_w[k] = csbl_pkg::clamp_sym(signed'(16'(mall_w)) - signed'(16'(mean_w[k])),
                                         lim_w);
      valid_zone = (zone_ff != 5'd0) && (32'(zone_ff) <= 32'(ZONE_COUNT));
      ix = valid_zone ? ZW'(zone_ff - 5'd1) : '0;
      had = flags_ff[ix];
      old_w[0] = old_ff[0];
      old_w[1] = old_ff[1];
      old_w[2] = old_ff[2];
      for (int k = 0; k < 3; k++) begin
         if (had) begin
            avg = 16'(old_w[k]) + corr_w[k];
            avg = (avg < 0) ? -((-avg) >>> 1) : (avg >>> 1);
         end else avg = corr_w[k];
         new_w[k] = 8'(csbl_pkg::clamp_sym(avg, 16'(csbl_pkg::CORR_MAX)));
      end
   end

   // Control sequencer.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= csbl_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csbl_pkg::ST_IDLE: if (req.valid) state_in = csbl_pkg::ST_DIVIDE;
         csbl_pkg::ST_DIVIDE: if (cnt_ff == 6'd31) state_in = csbl_pkg::ST_FINISH;
         csbl_pkg::ST_FINISH: state_in = csbl_pkg::ST_OUTPUT;
         csbl_pkg::ST_OUTPUT: if (rsp.ready) state_in = csbl_pkg::ST_IDLE;
         default: state_in = csbl_pkg::ST_IDLE;
      endcase
   end

   // Datapath: load, one quotient bit per cycle per cylinder, finish.
   logic [SW:0] trial [3];
   always_comb
      for (int k = 0; k < 3; k++) trial[k] = {rem_ff[k], quo_ff[k][SW-1]};

   always_ff @(posedge clock) begin
      if (reset) flags_ff <= '0;
      else if (state_ff == csbl_pkg::ST_FINISH && valid_zone && store_ff)
         flags_ff[ix] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (state_ff == csbl_pkg::ST_IDLE && req.valid) begin
         zone_ff <= req.zone_number;
         store_ff <= req.store_request;
         quo_ff[0] <= req.sum_first;
         quo_ff[1] <= req.sum_second;
         quo_ff[2] <= req.sum_third;
         den_ff[0] <= req.count_first;
         den_ff[1] <= req.count_second;
         den_ff[2] <= req.count_third;
         ack_ff[0] <= req.count_first >= 32'(min_ff) + 32'd1;
         ack_ff[1] <= req.count_second >= 32'(min_ff) + 32'd1;
         ack_ff[2] <= req.count_third >= 32'(min_ff) + 32'd1;
         for (int k = 0; k < 3; k++) rem_ff[k] <= '0;
         cnt_ff <= '0;
      end else if (state_ff == csbl_pkg::ST_DIVIDE) begin
         cnt_ff <= cnt_ff + 6'd1;
         // The learned entry of the zone is read while the dividers run.
         old_ff[0] <= mem1[ix];
         old_ff[1] <= mem2[ix];
         old_ff[2] <= mem3[ix];
         for (int k = 0; k < 3; k++) begin
            if (trial[k] >= {1'b0, den_ff[k]}) begin
               rem_ff[k] <= SW'(trial[k] - {1'b0, den_ff[k]});
               quo_ff[k] <= {quo_ff[k][SW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[k][SW-1:0];
               quo_ff[k] <= {quo_ff[k][SW-2:0], 1'b0};
            end
         end
      end else if (state_ff == csbl_pkg::ST_FINISH) begin
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= mean_w[k];
            c_ff[k] <= 8'(corr_w[k]);
         end
         mall_ff <= mall_w;
         ready_out_ff <= (&ack_ff) && (grp != 3'd0);
         err_ff <= store_ff && !valid_zone;
         if (valid_zone && store_ff) begin
            mem1[ix] <= new_w[0];
            mem2[ix] <= new_w[1];
            mem3[ix] <= new_w[2];
            for (int k = 0; k < 3; k++) t_ff[k] <= new_w[k];
         end else if (valid_zone && had) begin
            for (int k = 0; k < 3; k++) t_ff[k] <= old_w[k];
         end else begin
            for (int k = 0; k < 3; k++) t_ff[k] <= '0;
         end
      end
   end

   assign rsp.mean_first = m_ff[0];
   assign rsp.mean_second = m_ff[1];
   assign rsp.mean_third = m_ff[2];
   assign rsp.mean_all = mall_ff;
   assign rsp.learn_ready = ready_out_ff;
   assign rsp.corr_first = c_ff[0];
   assign rsp.corr_second = c_ff[1];
   assign rsp.corr_third = c_ff[2];
   assign rsp.table_first = t_ff[0];
   assign rsp.table_second = t_ff[1];
   assign rsp.table_third = t_ff[2];
   assign rsp.zone_error = err_ff;

endmodule
